### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/jst_pkg.sv
// ---------------------------------------------------------------------------
// JSON tokenizer package
// Shared types, codes and character helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package jst_pkg;

  localparam int NEST_DEPTH = 32;
  localparam int SP_W = $clog2(NEST_DEPTH + 1);
  localparam int SI_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  typedef enum logic [3:0] {
    K_NULL = 4'd0, K_BOOL = 4'd1, K_INT = 4'd2, K_DOUBLE = 4'd3, K_STR_END = 4'd4,
    K_ARR_START = 4'd5, K_ARR_END = 4'd6, K_OBJ_START = 4'd7, K_OBJ_END = 4'd8,
    K_TEXT = 4'd9, K_ERROR = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_CHAR = 3'd1, E_END = 3'd2, E_NEST = 3'd3, E_OVF = 3'd4
  } err_t;

  typedef enum logic [5:0] {
    G_VALUE   = 6'b000001,
    G_ARRAY0  = 6'b000010,
    G_ARRAYN  = 6'b000100,
    G_OBJECT0 = 6'b001000,
    G_OBJECTN = 6'b010000,
    G_KEY     = 6'b100000
  } gstate_t;

  typedef enum logic [15:0] {
    M_IDLE   = 16'h0001, M_SEP   = 16'h0002, M_STR    = 16'h0004, M_ESC   = 16'h0008,
    M_HEX    = 16'h0010, M_LT    = 16'h0020, M_LF     = 16'h0040, M_LN    = 16'h0080,
    M_NMINUS = 16'h0100, M_NZERO = 16'h0200, M_NINT   = 16'h0400, M_NDOT  = 16'h0800,
    M_NFRAC  = 16'h1000, M_NE    = 16'h2000, M_NESIGN = 16'h4000, M_NEDIG = 16'h8000
  } mode_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
    logic       ws;
    logic       dig;
    logic       alnum;
    logic       hex_ok;
    logic [3:0] hexv;
  } cls_t;

  typedef struct packed {
    kind_t       kind;
    logic        bv;
    logic [63:0] iv;
    logic [7:0]  tb;
    err_t        ec;
    logic        last;
  } res_t;

  typedef res_t [1:0] res_pair_t;

  typedef struct packed {
    logic       err;
    logic [1:0] push_n;
  } core_stat_t;

  function automatic res_t mk_res(kind_t k, logic bv, logic [63:0] iv, logic [7:0] tb,
                                  err_t ec);
    res_t r;
    r.kind = k;
    r.bv = bv;
    r.iv = iv;
    r.tb = tb;
    r.ec = ec;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic res_pair_t put(res_pair_t a, logic [1:0] n, res_t r);
    res_pair_t b;
    b = a;
    if (n == 2'd0) b[0] = r;
    else if (n == 2'd1) b[1] = r;
    return b;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] k);
    return (k == 2'd1) ? 3'd4 : 3'd3;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] k, logic [1:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: case (i) 2'd0: ch = "r"; 2'd1: ch = "u"; 2'd2: ch = "e"; default: ch = 8'h00; endcase
      2'd1: case (i) 2'd0: ch = "a"; 2'd1: ch = "l"; 2'd2: ch = "s"; default: ch = "e"; endcase
      default: case (i) 2'd0: ch = "u"; 2'd1: ch = "l"; 2'd2: ch = "l"; default: ch = 8'h00; endcase
    endcase
    return ch;
  endfunction

endpackage

### design/jst_front.sv
// ---------------------------------------------------------------------------
// JSON tokenizer front end
// Accept bytes, classify them and hold them in a short queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module jst_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_eoi,
  output logic          q_valid,
  input  logic          q_pop,
  output jst_pkg::cls_t q_head,
  output logic [2:0]    q_count
);
  import jst_pkg::*;

  cls_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  cls_t       cls;
  logic       push;

  always_comb begin
    cls.c = in_byte;
    cls.eoi = in_eoi;
    cls.ws = (in_byte == 8'h20) || (in_byte >= 8'd9 && in_byte <= 8'd13);
    cls.dig = (in_byte >= "0" && in_byte <= "9");
    cls.alnum = cls.dig || (in_byte >= "a" && in_byte <= "z") ||
                (in_byte >= "A" && in_byte <= "Z");
    cls.hex_ok = 1'b1;
    cls.hexv = 4'd0;
    if (cls.dig) cls.hexv = 4'(in_byte - 8'h30);
    else if (in_byte >= "a" && in_byte <= "f") cls.hexv = 4'(in_byte - 8'h57);
    else if (in_byte >= "A" && in_byte <= "F") cls.hexv = 4'(in_byte - 8'h37);
    else cls.hex_ok = 1'b0;
  end

  assign in_ready = (count != 3'd4);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 3'd0);
  assign q_head = q[rp];
  assign q_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (q_pop) rp <= rp + 2'd1;
      count <= count + {2'b0, push} - {2'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
  end

endmodule

### design/jst_core.sv
// ---------------------------------------------------------------------------
// JSON tokenizer back end
// Run grammar, nesting stack and lexer; produce up to two results per byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module jst_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  jst_pkg::cls_t      q_head,
  output logic               q_pop,
  input  logic [2:0]         out_count,
  output jst_pkg::res_pair_t res,
  output jst_pkg::core_stat_t stat
);
  import jst_pkg::*;

  gstate_t     grammar, grammar_next;
  logic [SP_W-1:0] sp, sp_next;
  mode_t       mode, mode_next;
  logic [2:0]  lit_idx, lit_idx_next;
  logic [15:0] hex_acc, hex_acc_next;
  logic [63:0] acc, acc_next;
  logic        neg, neg_next;
  logic        err, err_next;
  gstate_t     stack [NEST_DEPTH];

  logic            fire;
  logic            st_we;
  logic [SI_W-1:0] st_wa;
  gstate_t         st_wd;
  gstate_t         st_top;
  logic [SP_W-1:0] sp_dec;
  logic [1:0]      rc;
  res_pair_t       rs;
  logic            reproc;
  logic            sep;
  logic            bad;
  logic [7:0]      c;
  logic [1:0]      lk;
  logic [67:0]     mac;
  logic [63:0]     lim;
  mode_t           nm;
  logic            nm_ok;

  assign fire = q_valid && (err || out_count <= 3'd2);
  assign q_pop = fire;
  assign sp_dec = sp - 1'b1;
  assign st_top = stack[sp_dec[SI_W-1:0]];

  always_comb begin
    grammar_next = grammar;
    sp_next = sp;
    mode_next = mode;
    lit_idx_next = lit_idx;
    hex_acc_next = hex_acc;
    acc_next = acc;
    neg_next = neg;
    err_next = err;
    st_we = 1'b0;
    st_wa = sp[SI_W-1:0];
    st_wd = grammar;
    rc = 2'd0;
    rs = '0;
    reproc = 1'b0;
    sep = 1'b0;
    bad = 1'b0;
    c = q_head.c;
    lk = 2'd0;
    mac = '0;
    lim = '0;
    nm = M_IDLE;
    nm_ok = 1'b0;
    if (fire && !err) begin
      if (q_head.eoi) begin
        if (mode != M_IDLE) begin
          if (mode == M_LT || mode == M_LF || mode == M_LN) begin
            lk = (mode == M_LT) ? 2'd0 : (mode == M_LF) ? 2'd1 : 2'd2;
            if (lit_idx < lit_len(lk)) begin
              rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_END));
              rc = rc + 2'd1;
              err_next = 1'b1;
            end else begin
              if (mode == M_LN) rs = put(rs, rc, mk_res(K_NULL, 1'b0, '0, '0, E_NONE));
              else rs = put(rs, rc, mk_res(K_BOOL, mode == M_LT, '0, '0, E_NONE));
              rc = rc + 2'd1;
              mode_next = M_IDLE;
            end
          end else if (mode == M_NZERO || mode == M_NINT) begin
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (acc > lim) begin
              rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_OVF));
              rc = rc + 2'd1;
              err_next = 1'b1;
            end else begin
              rs = put(rs, rc, mk_res(K_INT, 1'b0, neg ? (64'd0 - acc) : acc, '0, E_NONE));
              rc = rc + 2'd1;
              mode_next = M_IDLE;
            end
          end else if (mode == M_NFRAC || mode == M_NEDIG) begin
            rs = put(rs, rc, mk_res(K_DOUBLE, 1'b0, '0, '0, E_NONE));
            rc = rc + 2'd1;
            mode_next = M_IDLE;
          end else begin
            rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_END));
            rc = rc + 2'd1;
            err_next = 1'b1;
          end
        end
        if (!err_next && sp != '0) begin
          rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_END));
          rc = rc + 2'd1;
          err_next = 1'b1;
        end else if (!err_next) begin
          mode_next = M_IDLE;
        end
      end else begin
        unique case (mode)
          M_IDLE, M_SEP: begin
            reproc = 1'b1;
            sep = (mode == M_SEP);
          end
          M_STR: begin
            if (c == 8'h22) begin
              mode_next = M_IDLE;
              rs = put(rs, rc, mk_res(K_STR_END, 1'b0, '0, '0, E_NONE));
              rc = rc + 2'd1;
            end else if (c == 8'h5C) begin
              mode_next = M_ESC;
            end else begin
              rs = put(rs, rc, mk_res(K_TEXT, 1'b0, '0, c, E_NONE));
              rc = rc + 2'd1;
            end
          end
          M_ESC: begin
            nm_ok = 1'b1;
            case (c)
              8'h22, 8'h5C, 8'h2F: lim[7:0] = c;
              "b": lim[7:0] = 8'd8;
              "f": lim[7:0] = 8'd12;
              "n": lim[7:0] = 8'd10;
              "r": lim[7:0] = 8'd13;
              "t": lim[7:0] = 8'd9;
              default: nm_ok = 1'b0;
            endcase
            if (c == "u" || c == "U") begin
              mode_next = M_HEX;
              lit_idx_next = 3'd0;
              hex_acc_next = 16'd0;
            end else if (nm_ok) begin
              mode_next = M_STR;
              rs = put(rs, rc, mk_res(K_TEXT, 1'b0, '0, lim[7:0], E_NONE));
              rc = rc + 2'd1;
            end else begin
              rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_CHAR));
              rc = rc + 2'd1;
              err_next = 1'b1;
            end
          end
          M_HEX: begin
            if (!q_head.hex_ok) begin
              rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_CHAR));
              rc = rc + 2'd1;
              err_next = 1'b1;
            end else begin
              hex_acc_next = {hex_acc[11:0], q_head.hexv};
              lit_idx_next = lit_idx + 3'd1;
              if (lit_idx_next >= 3'd4) begin
                lit_idx_next = 3'd0;
                mode_next = M_STR;
                rs = put(rs, rc, mk_res(K_TEXT, 1'b0, '0, hex_acc_next[7:0], E_NONE));
                rc = rc + 2'd1;
              end
            end
          end
          M_LT, M_LF, M_LN: begin
            lk = (mode == M_LT) ? 2'd0 : (mode == M_LF) ? 2'd1 : 2'd2;
            if (lit_idx < lit_len(lk)) begin
              if (c == lit_char(lk, lit_idx[1:0])) begin
                lit_idx_next = lit_idx + 3'd1;
              end else begin
                rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_CHAR));
                rc = rc + 2'd1;
                err_next = 1'b1;
              end
            end else if (q_head.alnum) begin
              rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_CHAR));
              rc = rc + 2'd1;
              err_next = 1'b1;
            end else begin
              if (mode == M_LN) rs = put(rs, rc, mk_res(K_NULL, 1'b0, '0, '0, E_NONE));
              else rs = put(rs, rc, mk_res(K_BOOL, mode == M_LT, '0, '0, E_NONE));
              rc = rc + 2'd1;
              mode_next = M_IDLE;
              reproc = 1'b1;
            end
          end
          M_NMINUS, M_NZERO, M_NINT, M_NDOT, M_NFRAC, M_NE, M_NESIGN, M_NEDIG: begin
            unique case (mode)
              M_NMINUS: begin
                nm_ok = q_head.dig;
                nm = (c == "0") ? M_NZERO : M_NINT;
              end
              M_NZERO, M_NINT, M_NFRAC: begin
                if (q_head.dig && mode != M_NZERO) begin
                  nm_ok = 1'b1; nm = mode;
                end else if (c == "." && mode != M_NFRAC) begin
                  nm_ok = 1'b1; nm = M_NDOT;
                end else if (c == "e" || c == "E") begin
                  nm_ok = 1'b1; nm = M_NE;
                end
              end
              M_NDOT: begin
                nm_ok = q_head.dig; nm = M_NFRAC;
              end
              M_NE: begin
                if (c == "+" || c == "-") begin
                  nm_ok = 1'b1; nm = M_NESIGN;
                end else begin
                  nm_ok = q_head.dig; nm = M_NEDIG;
                end
              end
              default: begin
                nm_ok = q_head.dig; nm = M_NEDIG;
              end
            endcase
            if (nm_ok) begin
              if (nm == M_NINT) begin
                mac = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {60'd0, c - 8'h30};
                acc_next = (mac[67:64] != 4'd0) ? '1 : mac[63:0];
              end
              mode_next = nm;
              rs = put(rs, rc, mk_res(K_TEXT, 1'b0, '0, c, E_NONE));
              rc = rc + 2'd1;
            end else if (mode == M_NZERO || mode == M_NINT) begin
              lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
              if (acc > lim) begin
                rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_OVF));
                rc = rc + 2'd1;
                err_next = 1'b1;
              end else begin
                rs = put(rs, rc, mk_res(K_INT, 1'b0, neg ? (64'd0 - acc) : acc, '0, E_NONE));
                rc = rc + 2'd1;
                mode_next = M_IDLE;
                reproc = 1'b1;
              end
            end else if (mode == M_NFRAC || mode == M_NEDIG) begin
              rs = put(rs, rc, mk_res(K_DOUBLE, 1'b0, '0, '0, E_NONE));
              rc = rc + 2'd1;
              mode_next = M_IDLE;
              reproc = 1'b1;
            end else begin
              rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_CHAR));
              rc = rc + 2'd1;
              err_next = 1'b1;
            end
          end
          default: ;
        endcase

        if (reproc && !err_next && !q_head.ws) begin
          if (!sep && c == "]") begin
            if (grammar == G_ARRAY0 || grammar == G_ARRAYN) begin
              if (sp != '0) begin
                sp_next = sp_dec;
                grammar_next = st_top;
              end else begin
                grammar_next = G_VALUE;
              end
              rs = put(rs, rc, mk_res(K_ARR_END, 1'b0, '0, '0, E_NONE));
              rc = rc + 2'd1;
            end else begin
              bad = 1'b1;
            end
          end else if (!sep && c == "}") begin
            if (grammar == G_OBJECT0 || grammar == G_OBJECTN) begin
              if (sp != '0) begin
                sp_next = sp_dec;
                grammar_next = st_top;
              end else begin
                grammar_next = G_VALUE;
              end
              rs = put(rs, rc, mk_res(K_OBJ_END, 1'b0, '0, '0, E_NONE));
              rc = rc + 2'd1;
            end else begin
              bad = 1'b1;
            end
          end else if (!sep && c == ",") begin
            if (grammar == G_ARRAYN) begin
              mode_next = M_SEP;
            end else if (grammar == G_OBJECTN) begin
              grammar_next = G_OBJECT0;
              mode_next = M_SEP;
            end else begin
              bad = 1'b1;
            end
          end else if (!sep && c == ":") begin
            if (grammar == G_KEY) begin
              grammar_next = G_OBJECTN;
              mode_next = M_SEP;
            end else begin
              bad = 1'b1;
            end
          end else if (!sep && grammar != G_VALUE && grammar != G_ARRAY0 &&
                       grammar != G_OBJECT0) begin
            bad = 1'b1;
          end else begin
            mode_next = M_IDLE;
            if (grammar == G_OBJECT0) begin
              if (c != 8'h22) bad = 1'b1;
              else grammar_next = G_KEY;
            end else if (grammar == G_ARRAY0) begin
              grammar_next = G_ARRAYN;
            end
            if (!bad) begin
              if (c == "[" || c == "{") begin
                if (sp >= SP_W'(NEST_DEPTH)) begin
                  rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_NEST));
                  rc = rc + 2'd1;
                  err_next = 1'b1;
                end else begin
                  st_we = 1'b1;
                  st_wd = grammar_next;
                  sp_next = sp + 1'b1;
                  grammar_next = (c == "[") ? G_ARRAY0 : G_OBJECT0;
                  rs = put(rs, rc, mk_res((c == "[") ? K_ARR_START : K_OBJ_START, 1'b0,
                                          '0, '0, E_NONE));
                  rc = rc + 2'd1;
                end
              end else if (c == 8'h22) begin
                mode_next = M_STR;
              end else if (c == "t" || c == "f" || c == "n") begin
                mode_next = (c == "t") ? M_LT : (c == "f") ? M_LF : M_LN;
                lit_idx_next = 3'd0;
              end else if (c == "-" || q_head.dig) begin
                neg_next = (c == "-");
                acc_next = '0;
                if (c == "-") begin
                  mode_next = M_NMINUS;
                end else if (c == "0") begin
                  mode_next = M_NZERO;
                end else begin
                  mode_next = M_NINT;
                  acc_next = {56'd0, c - 8'h30};
                end
                rs = put(rs, rc, mk_res(K_TEXT, 1'b0, '0, c, E_NONE));
                rc = rc + 2'd1;
              end else begin
                bad = 1'b1;
              end
            end
          end
          if (bad) begin
            rs = put(rs, rc, mk_res(K_ERROR, 1'b0, '0, '0, E_CHAR));
            rc = rc + 2'd1;
            err_next = 1'b1;
          end
        end
      end
      if (rc == 2'd1) rs[0].last = 1'b1;
      else if (rc == 2'd2) rs[1].last = 1'b1;
    end
  end

  assign res = rs;
  assign stat.err = err;
  assign stat.push_n = rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      grammar <= G_VALUE;
      sp <= '0;
      mode <= M_IDLE;
      lit_idx <= '0;
      hex_acc <= '0;
      acc <= '0;
      neg <= 1'b0;
      err <= 1'b0;
    end else begin
      grammar <= grammar_next;
      sp <= sp_next;
      mode <= mode_next;
      lit_idx <= lit_idx_next;
      hex_acc <= hex_acc_next;
      acc <= acc_next;
      neg <= neg_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) stack[st_wa] <= st_wd;
  end

endmodule

### design/jst_outq.sv
// ---------------------------------------------------------------------------
// JSON tokenizer result queue
// Take up to two results per cycle, deliver one beat per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module jst_outq (
  input  logic               clk,
  input  logic               rst,
  input  jst_pkg::res_pair_t res,
  input  logic [1:0]         push_n,
  output logic               out_valid,
  input  logic               out_ready,
  output jst_pkg::res_t      out_res,
  output logic [2:0]         count
);
  import jst_pkg::*;

  res_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop = out_valid && out_ready;
  assign out_res = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + push_n;
      if (pop) rp <= rp + 2'd1;
      count <= count + {1'b0, push_n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q[wp] <= res[0];
    if (push_n == 2'd2) q[wp + 2'd1] <= res[1];
  end

endmodule

### design/json_stream_tokenizer_unit.sv
// Path: an accepted byte is held in the front queue, lexed by the back end, and its
//   results are written into the result queue, which drives m_axis.
// Throughput: one byte per cycle while the front queue has room and the result queue
//   holds at most two results; a byte that yields two results needs an output beat
//   for each, so the result queue sets the sustained rate.
// Reset: synchronous, active high; clears grammar, lexer, stack pointer and queues at once. Errors stick until reset.
// ---------------------------------------------------------------------------
// JSON stream tokenizer
// Front end classifies bytes into a queue; back end lexes and emits tokens.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module json_stream_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // bool_value, int_value, text_byte, error_code, zeros
  output logic [3:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // last_of_run
);
  import jst_pkg::*;

  logic       q_valid;
  logic       q_pop;
  cls_t       q_head;
  logic [2:0] q_count;
  res_pair_t  res;
  core_stat_t stat;
  res_t       out_res;
  logic [2:0] oq_count;

  jst_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_eoi(s_axis_tlast),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head), .q_count(q_count)
  );

  jst_core u_core (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_count(oq_count), .res(res), .stat(stat)
  );

  jst_outq u_outq (
    .clk(clk), .rst(rst),
    .res(res), .push_n(stat.push_n),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_res(out_res), .count(oq_count)
  );

  assign m_axis_tdata = {4'd0, out_res.ec, out_res.tb, out_res.iv, out_res.bv};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  `ASSERT_IMP(a_room, clk, rst, stat.push_n != 2'd0, oq_count <= 3'd2)
  `ASSERT_IMP(a_quiet, clk, rst, stat.err, stat.push_n == 2'd0)
  `ASSERT_IMP(a_full, clk, rst, !s_axis_tready, q_count == 3'd4)
  `ASSERT_NXT(a_oq_bound, clk, rst, 1'b1, oq_count <= 3'd4)

endmodule
